// ===== sv/potl_pkg.sv =====
// Shared codes, field widths and control types for the priority-ordered task list.
package potl_pkg;

  localparam int OP_W      = 2;
  localparam int PRIO_IN_W = 16;
  localparam int SLOT_IN_W = 5;
  localparam int SLOT_OUT_W = 5;
  localparam int STATUS_W  = 2;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
  localparam logic [OP_W-1:0] OP_WALK   = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_SLOT = 2'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd3;

  // Write enables of the link and priority stores.
  typedef struct packed {
    logic next_we;
    logic prev_we;
    logic prio_we;
  } potl_wen_t;

endpackage

// ===== sv/potl_store.sv =====
// Link and priority memories with a registered shared read port; head links in flops.
module potl_store import potl_pkg::*; #(
  parameter int TASK_SLOTS = 32,
  parameter int PRIO_BITS  = 16,
  parameter int SW         = $clog2(TASK_SLOTS)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [SW-1:0]        rd_addr,
  output logic [SW-1:0]        rd_next,
  output logic [SW-1:0]        rd_prev,
  output logic [PRIO_BITS-1:0] rd_prio,
  output logic [SW-1:0]        head_next,
  input  potl_wen_t            wen,
  input  logic [SW-1:0]        next_wa,
  input  logic [SW-1:0]        next_wd,
  input  logic [SW-1:0]        prev_wa,
  input  logic [SW-1:0]        prev_wd,
  input  logic [SW-1:0]        prio_wa,
  input  logic [PRIO_BITS-1:0] prio_wd
);

  localparam logic [SW-1:0] HEAD = '0;

  logic [SW-1:0]        next_mem [TASK_SLOTS];
  logic [SW-1:0]        prev_mem [TASK_SLOTS];
  logic [PRIO_BITS-1:0] prio_mem [TASK_SLOTS];

  logic [SW-1:0]        head_next_r;
  logic [SW-1:0]        head_prev_r;
  logic [SW-1:0]        rd_next_r;
  logic [SW-1:0]        rd_prev_r;
  logic [PRIO_BITS-1:0] rd_prio_r;

  // Head links live in flops so reset can make the head point to itself.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_next_r <= HEAD;
      head_prev_r <= HEAD;
    end else begin
      if (wen.next_we && next_wa == HEAD) head_next_r <= next_wd;
      if (wen.prev_we && prev_wa == HEAD) head_prev_r <= prev_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (wen.next_we && next_wa != HEAD) next_mem[next_wa] <= next_wd;
    if (wen.prev_we && prev_wa != HEAD) prev_mem[prev_wa] <= prev_wd;
    if (wen.prio_we) prio_mem[prio_wa] <= prio_wd;
  end

  always_ff @(posedge clk) begin
    if (rd_addr == HEAD) begin
      rd_next_r <= head_next_r;
      rd_prev_r <= head_prev_r;
    end else begin
      rd_next_r <= next_mem[rd_addr];
      rd_prev_r <= prev_mem[rd_addr];
    end
    rd_prio_r <= prio_mem[rd_addr];
  end

  assign rd_next   = rd_next_r;
  assign rd_prev   = rd_prev_r;
  assign rd_prio   = rd_prio_r;
  assign head_next = head_next_r;

endmodule

// ===== sv/priority_ordered_task_list.sv =====
// Top level: command sequencer for the priority-ordered task list.
//
// Commands are taken when start is high and busy is low; results appear on the
// out_ ports for one cycle each, flagged by out_valid, and cannot be held off.
// A remove gives its result from the S_REM state (a bad remove answers in the
// cycle after start and leaves busy low). Insert walks the ring one link per
// cycle while a slot counter searches for the lowest free slot alongside it;
// busy stays high through that search and, when a slot is free, the S_LINK1
// and S_LINK2 writes, and the result appears as busy drops. A walk emits one
// word per cycle, the first one coming out of the S_WALK state. Every step
// shares the single read port of the link memories.
module priority_ordered_task_list import potl_pkg::*; #(
  parameter int TASK_SLOTS = 32,
  parameter int PRIO_BITS  = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [OP_W-1:0]       in_op,
  input  logic [PRIO_IN_W-1:0]  in_priority_req,
  input  logic [SLOT_IN_W-1:0]  in_slot,
  output logic                  out_valid,
  output logic [SLOT_OUT_W-1:0] out_task_slot,
  output logic [STATUS_W-1:0]   out_status,
  output logic                  out_last
);

  localparam int SW = $clog2(TASK_SLOTS);
  localparam logic [SW-1:0] HEAD      = '0;
  localparam logic [SW-1:0] LAST_SLOT = SW'(TASK_SLOTS - 1);
  localparam logic [SW-1:0] WALK_MAX  = SW'(TASK_SLOTS - 2);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_INS   = 6'b000010,
    S_LINK1 = 6'b000100,
    S_LINK2 = 6'b001000,
    S_REM   = 6'b010000,
    S_WALK  = 6'b100000
  } state_t;

  state_t                 state_r, state_nxt;
  logic [PRIO_BITS-1:0]   prio_r, prio_nxt;
  logic [SW-1:0]          cur_r, cur_nxt;
  logic [SW-1:0]          cand_r, cand_nxt;
  logic [SW-1:0]          id_r, id_nxt;
  logic [SW-1:0]          scan_idx_r, scan_idx_nxt;
  logic                   scan_done_r, scan_done_nxt;
  logic                   walk_done_r, walk_done_nxt;
  logic                   full_r, full_nxt;
  logic [SW-1:0]          cnt_r, cnt_nxt;
  logic [TASK_SLOTS-1:0]  used_r, used_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [SLOT_OUT_W-1:0]  out_task_slot_r, out_task_slot_nxt;
  logic [STATUS_W-1:0]    out_status_r, out_status_nxt;
  logic                   out_last_r, out_last_nxt;

  logic [SW-1:0]          rd_addr, rd_next, rd_prev, head_next;
  logic [PRIO_BITS-1:0]   rd_prio;
  potl_wen_t              wen;
  logic [SW-1:0]          next_wa, next_wd, prev_wa, prev_wd, prio_wa;
  logic [PRIO_BITS-1:0]   prio_wd;
  logic [SW-1:0]          slot_ix;
  logic                   bad_remove;
  logic                   walk_last;

  potl_store #(
    .TASK_SLOTS (TASK_SLOTS),
    .PRIO_BITS  (PRIO_BITS),
    .SW         (SW)
  ) u_store (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_addr   (rd_addr),
    .rd_next   (rd_next),
    .rd_prev   (rd_prev),
    .rd_prio   (rd_prio),
    .head_next (head_next),
    .wen       (wen),
    .next_wa   (next_wa),
    .next_wd   (next_wd),
    .prev_wa   (prev_wa),
    .prev_wd   (prev_wd),
    .prio_wa   (prio_wa),
    .prio_wd   (prio_wd)
  );

  assign slot_ix    = SW'(in_slot);
  assign bad_remove = (in_slot == '0) || (32'(in_slot) >= TASK_SLOTS) || !used_r[slot_ix];
  assign walk_last  = (rd_next == HEAD) || (cnt_r == WALK_MAX);

  always_comb begin
    state_nxt         = state_r;
    prio_nxt          = prio_r;
    cur_nxt           = cur_r;
    cand_nxt          = cand_r;
    id_nxt            = id_r;
    scan_idx_nxt      = scan_idx_r;
    scan_done_nxt     = scan_done_r;
    walk_done_nxt     = walk_done_r;
    full_nxt          = full_r;
    cnt_nxt           = cnt_r;
    used_nxt          = used_r;
    out_valid_nxt     = 1'b0;
    out_task_slot_nxt = out_task_slot_r;
    out_status_nxt    = out_status_r;
    out_last_nxt      = out_last_r;
    rd_addr           = cand_r;
    wen               = '0;
    next_wa           = cur_r;
    next_wd           = id_r;
    prev_wa           = cand_r;
    prev_wd           = id_r;
    prio_wa           = id_r;
    prio_wd           = prio_r;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          case (in_op)
            OP_INSERT: begin
              prio_nxt      = PRIO_BITS'(in_priority_req);
              scan_idx_nxt  = SW'(1);
              scan_done_nxt = 1'b0;
              walk_done_nxt = 1'b0;
              full_nxt      = 1'b0;
              cur_nxt       = HEAD;
              cand_nxt      = head_next;
              rd_addr       = head_next;
              state_nxt     = S_INS;
            end
            OP_REMOVE: begin
              if (bad_remove) begin
                out_valid_nxt     = 1'b1;
                out_task_slot_nxt = in_slot;
                out_status_nxt    = ST_BAD_SLOT;
                out_last_nxt      = 1'b1;
              end else begin
                rd_addr   = slot_ix;
                cand_nxt  = slot_ix;
                state_nxt = S_REM;
              end
            end
            OP_WALK: begin
              if (head_next == HEAD) begin
                out_valid_nxt     = 1'b1;
                out_task_slot_nxt = '0;
                out_status_nxt    = ST_EMPTY;
                out_last_nxt      = 1'b1;
              end else begin
                rd_addr   = head_next;
                cand_nxt  = head_next;
                cnt_nxt   = '0;
                state_nxt = S_WALK;
              end
            end
            default: ;
          endcase
        end
      end

      S_INS: begin
        // Advance until the next task is the head or has a higher priority.
        if (!walk_done_r) begin
          if (cand_r == HEAD || rd_prio > prio_r) begin
            walk_done_nxt = 1'b1;
          end else begin
            cur_nxt  = cand_r;
            cand_nxt = rd_next;
            rd_addr  = rd_next;
          end
        end
        if (!scan_done_r) begin
          if (!used_r[scan_idx_r]) begin
            id_nxt        = scan_idx_r;
            scan_done_nxt = 1'b1;
          end else if (scan_idx_r == LAST_SLOT) begin
            full_nxt      = 1'b1;
            scan_done_nxt = 1'b1;
          end else begin
            scan_idx_nxt = scan_idx_r + SW'(1);
          end
        end
        if (scan_done_r && walk_done_r) begin
          if (full_r) begin
            out_valid_nxt     = 1'b1;
            out_task_slot_nxt = '0;
            out_status_nxt    = ST_FULL;
            out_last_nxt      = 1'b1;
            state_nxt         = S_IDLE;
          end else begin
            state_nxt = S_LINK1;
          end
        end
      end

      S_LINK1: begin
        wen          = '{next_we: 1'b1, prev_we: 1'b1, prio_we: 1'b1};
        next_wa      = id_r;
        next_wd      = cand_r;
        prev_wa      = id_r;
        prev_wd      = cur_r;
        used_nxt[id_r] = 1'b1;
        state_nxt    = S_LINK2;
      end

      S_LINK2: begin
        wen               = '{next_we: 1'b1, prev_we: 1'b1, prio_we: 1'b0};
        next_wa           = cur_r;
        next_wd           = id_r;
        prev_wa           = cand_r;
        prev_wd           = id_r;
        out_valid_nxt     = 1'b1;
        out_task_slot_nxt = SLOT_OUT_W'(id_r);
        out_status_nxt    = ST_OK;
        out_last_nxt      = 1'b1;
        state_nxt         = S_IDLE;
      end

      S_REM: begin
        // Splice the neighbors together and drop the slot.
        wen               = '{next_we: 1'b1, prev_we: 1'b1, prio_we: 1'b0};
        next_wa           = rd_prev;
        next_wd           = rd_next;
        prev_wa           = rd_next;
        prev_wd           = rd_prev;
        used_nxt[cand_r]  = 1'b0;
        out_valid_nxt     = 1'b1;
        out_task_slot_nxt = SLOT_OUT_W'(cand_r);
        out_status_nxt    = ST_OK;
        out_last_nxt      = 1'b1;
        state_nxt         = S_IDLE;
      end

      S_WALK: begin
        out_valid_nxt     = 1'b1;
        out_task_slot_nxt = SLOT_OUT_W'(cand_r);
        out_status_nxt    = ST_OK;
        out_last_nxt      = walk_last;
        if (walk_last) begin
          state_nxt = S_IDLE;
        end else begin
          cand_nxt = rd_next;
          rd_addr  = rd_next;
          cnt_nxt  = cnt_r + SW'(1);
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      used_r      <= TASK_SLOTS'(1);
      out_valid_r <= 1'b0;
      scan_done_r <= 1'b0;
      walk_done_r <= 1'b0;
      full_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      out_valid_r <= out_valid_nxt;
      scan_done_r <= scan_done_nxt;
      walk_done_r <= walk_done_nxt;
      full_r      <= full_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prio_r          <= prio_nxt;
    cur_r           <= cur_nxt;
    cand_r          <= cand_nxt;
    id_r            <= id_nxt;
    scan_idx_r      <= scan_idx_nxt;
    cnt_r           <= cnt_nxt;
    out_task_slot_r <= out_task_slot_nxt;
    out_status_r    <= out_status_nxt;
    out_last_r      <= out_last_nxt;
  end

  assign busy          = (state_r != S_IDLE);
  assign out_valid     = out_valid_r;
  assign out_task_slot = out_task_slot_r;
  assign out_status    = out_status_r;
  assign out_last      = out_last_r;

endmodule

// ===== sv/potl_checker.sv =====
// Port-level checks for the priority-ordered task list, bound to the top level.
module potl_checker import potl_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  start,
  input logic                  busy,
  input logic [OP_W-1:0]       in_op,
  input logic [PRIO_IN_W-1:0]  in_priority_req,
  input logic [SLOT_IN_W-1:0]  in_slot,
  input logic                  out_valid,
  input logic [SLOT_OUT_W-1:0] out_task_slot,
  input logic [STATUS_W-1:0]   out_status,
  input logic                  out_last
);

  // A walk emits its words back to back until the last one.
  a_walk_streams: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |=> out_valid)
    else $error("walk word stream broke before last");

  a_busy_mid_walk: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> busy)
    else $error("block idle in the middle of a walk");

  a_error_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_last)
    else $error("error word not marked last");

  a_head_remove: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_op == OP_REMOVE && in_slot == '0
    |=> out_valid && out_status == ST_BAD_SLOT && out_task_slot == '0)
    else $error("remove of the head not flagged");

  a_empty_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_EMPTY || out_status == ST_FULL) |-> out_task_slot == '0)
    else $error("empty or full word carries a slot");

endmodule

bind priority_ordered_task_list potl_checker u_potl_checker (.*);

// ===== sim/testbench.sv =====
// Self-checking testbench for the priority-ordered task list: directed table, then random traffic.
module testbench;
  import potl_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_SLOTS = 32;
  localparam int MAX_TASKS = NUM_SLOTS - 1;
  localparam int RANDOM_ITEMS = 210;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = NUM_SLOTS + 8;
  localparam logic [OP_W-1:0] OP_NONE = 2'd3;

  typedef struct packed {
    logic [SLOT_OUT_W-1:0] task_slot;
    logic [STATUS_W-1:0]   status;
    logic                  last;
  } task_word_t;

  typedef struct packed {
    logic [OP_W-1:0]       op;
    logic [PRIO_IN_W-1:0]  prio;
    logic [SLOT_IN_W-1:0]  slot;
    logic                  typed;
    logic [SLOT_OUT_W-1:0] e_slot;
    logic [STATUS_W-1:0]   e_status;
  } plan_row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  start;
  logic                  busy;
  logic [OP_W-1:0]       in_op;
  logic [PRIO_IN_W-1:0]  in_priority_req;
  logic [SLOT_IN_W-1:0]  in_slot;
  logic                  out_valid;
  logic [SLOT_OUT_W-1:0] out_task_slot;
  logic [STATUS_W-1:0]   out_status;
  logic                  out_last;

  // Expectation typed into the directed table for the word on the inputs.
  logic                  row_typed;
  logic [SLOT_OUT_W-1:0] row_slot;
  logic [STATUS_W-1:0]   row_status;

  // Shadow copy of the ring.
  logic [SLOT_OUT_W-1:0] ring_next [NUM_SLOTS];
  logic [SLOT_OUT_W-1:0] ring_prev [NUM_SLOTS];
  logic [PRIO_IN_W-1:0]  slot_prio [NUM_SLOTS];
  bit                    slot_taken [NUM_SLOTS];

  task_word_t step_words [NUM_SLOTS];
  task_word_t expected_words [$];

  int  errors = 0;
  int  cycles = 0;
  int  items_sent = 0;
  bit  no_idle = 1'b0;

  priority_ordered_task_list #(
    .TASK_SLOTS(NUM_SLOTS),
    .PRIO_BITS (16)
  ) u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_op          (in_op),
    .in_priority_req(in_priority_req),
    .in_slot        (in_slot),
    .out_valid      (out_valid),
    .out_task_slot  (out_task_slot),
    .out_status     (out_status),
    .out_last       (out_last)
  );

  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic task_word_t make_word(logic [SLOT_OUT_W-1:0] s,
                                           logic [STATUS_W-1:0] st, logic l);
    task_word_t w;
    w.task_slot = s;
    w.status = st;
    w.last = l;
    return w;
  endfunction

  function automatic void clear_ring();
    for (int i = 0; i < NUM_SLOTS; i++) begin
      ring_next[i] = '0;
      ring_prev[i] = '0;
      slot_prio[i] = '0;
      slot_taken[i] = 1'b0;
    end
    slot_taken[0] = 1'b1;
  endfunction

  // Apply one command to the shadow ring; fill step_words, return their count.
  function automatic int apply_command(logic [OP_W-1:0] op, logic [PRIO_IN_W-1:0] prio,
                                       logic [SLOT_IN_W-1:0] slot);
    int id;
    int cur;
    int nxt;
    int count;
    case (op)
      OP_INSERT: begin
        id = 1;
        while (id < NUM_SLOTS && slot_taken[id]) id++;
        if (id >= NUM_SLOTS) begin
          step_words[0] = make_word('0, ST_FULL, 1'b1);
          return 1;
        end
        // Skip every task of lower or equal priority.
        cur = 0;
        for (int steps = 0; steps < NUM_SLOTS; steps++) begin
          nxt = int'(ring_next[cur]);
          if (nxt == 0 || slot_prio[nxt] > prio) break;
          cur = nxt;
        end
        nxt = int'(ring_next[cur]);
        slot_prio[id] = prio;
        ring_prev[id] = cur[SLOT_OUT_W-1:0];
        ring_next[id] = nxt[SLOT_OUT_W-1:0];
        ring_next[cur] = id[SLOT_OUT_W-1:0];
        ring_prev[nxt] = id[SLOT_OUT_W-1:0];
        slot_taken[id] = 1'b1;
        step_words[0] = make_word(id[SLOT_OUT_W-1:0], ST_OK, 1'b1);
        return 1;
      end
      OP_REMOVE: begin
        if (slot == 0 || !slot_taken[slot]) begin
          step_words[0] = make_word(slot, ST_BAD_SLOT, 1'b1);
          return 1;
        end
        ring_next[ring_prev[slot]] = ring_next[slot];
        ring_prev[ring_next[slot]] = ring_prev[slot];
        slot_taken[slot] = 1'b0;
        step_words[0] = make_word(slot, ST_OK, 1'b1);
        return 1;
      end
      OP_WALK: begin
        cur = int'(ring_next[0]);
        if (cur == 0) begin
          step_words[0] = make_word('0, ST_EMPTY, 1'b1);
          return 1;
        end
        count = 0;
        while (cur != 0 && count < MAX_TASKS) begin
          step_words[count] = make_word(cur[SLOT_OUT_W-1:0], ST_OK, 1'b0);
          count++;
          cur = int'(ring_next[cur]);
        end
        step_words[count-1].last = 1'b1;
        return count;
      end
      default: return 0;
    endcase
  endfunction

  function automatic int task_count();
    int n;
    n = 0;
    for (int i = 1; i < NUM_SLOTS; i++) if (slot_taken[i]) n++;
    return n;
  endfunction

  function automatic logic [SLOT_IN_W-1:0] pick_taken_slot();
    int list [$];
    for (int i = 1; i < NUM_SLOTS; i++) if (slot_taken[i]) list.push_back(i);
    if (list.size() == 0) return '0;
    return SLOT_IN_W'(list[$urandom_range(0, list.size() - 1)]);
  endfunction

  function automatic logic [SLOT_IN_W-1:0] pick_any_slot();
    return SLOT_IN_W'($urandom_range(0, NUM_SLOTS - 1));
  endfunction

  function automatic logic [PRIO_IN_W-1:0] pick_prio();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return PRIO_IN_W'($urandom_range(0, 3));
    if (r < 6) return ($urandom_range(0, 1) == 1) ? 16'hFFFF : 16'h0000;
    return PRIO_IN_W'($urandom_range(0, 65535));
  endfunction

  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic issue_command(logic [OP_W-1:0] op, logic [PRIO_IN_W-1:0] prio,
                               logic [SLOT_IN_W-1:0] slot, logic typed = 1'b0,
                               logic [SLOT_OUT_W-1:0] e_slot = '0,
                               logic [STATUS_W-1:0] e_status = ST_OK);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start <= 1'b1;
    in_op <= op;
    in_priority_req <= prio;
    in_slot <= slot;
    row_typed <= typed;
    row_slot <= e_slot;
    row_status <= e_status;
    do @(posedge clk); while (busy !== 1'b0);
    if (op != OP_NONE) items_sent++;
    @(negedge clk);
  endtask

  task automatic issue_random();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) issue_command(OP_INSERT, pick_prio(), pick_any_slot());
    else if (r < 70) issue_command(OP_REMOVE, pick_prio(), pick_taken_slot());
    else if (r < 80) issue_command(OP_REMOVE, pick_prio(), pick_any_slot());
    else if (r < 95) issue_command(OP_WALK, pick_prio(), pick_any_slot());
    else issue_command(OP_NONE, pick_prio(), pick_any_slot());
  endtask

  // Predict on acceptance, then check any word on the result ports.
  always @(posedge clk) begin : check_words
    int n;
    task_word_t exp_w;
    if (rst_n) begin
      if (start && busy === 1'b0) begin
        n = apply_command(in_op, in_priority_req, in_slot);
        if (row_typed && n > 0)
          expected_words.push_back(make_word(row_slot, row_status, 1'b1));
        else
          for (int i = 0; i < n; i++) expected_words.push_back(step_words[i]);
      end
      if (out_valid === 1'b1) begin
        if (expected_words.size() == 0) begin
          $display("%0t: unexpected word: slot %0d status %0d last %0d",
                   $time, out_task_slot, out_status, out_last);
          errors++;
        end else begin
          exp_w = expected_words.pop_front();
          if (out_task_slot !== exp_w.task_slot) begin
            $display("%0t: task_slot expected %0d actual %0d",
                     $time, exp_w.task_slot, out_task_slot);
            errors++;
          end
          if (out_status !== exp_w.status) begin
            $display("%0t: status expected %0d actual %0d", $time, exp_w.status, out_status);
            errors++;
          end
          if (out_last !== exp_w.last) begin
            $display("%0t: last expected %0d actual %0d", $time, exp_w.last, out_last);
            errors++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

  plan_row_t plan [22] = '{
    '{OP_WALK,   16'h0000, 5'd0,  1'b1, 5'd0,  ST_EMPTY},
    '{OP_REMOVE, 16'h0000, 5'd0,  1'b1, 5'd0,  ST_BAD_SLOT},
    '{OP_REMOVE, 16'h0000, 5'd5,  1'b1, 5'd5,  ST_BAD_SLOT},
    '{OP_REMOVE, 16'hFFFF, 5'd31, 1'b1, 5'd31, ST_BAD_SLOT},
    '{OP_INSERT, 16'hFFFF, 5'd0,  1'b1, 5'd1,  ST_OK},
    '{OP_INSERT, 16'h0000, 5'd31, 1'b1, 5'd2,  ST_OK},
    '{OP_INSERT, 16'h8000, 5'd0,  1'b1, 5'd3,  ST_OK},
    '{OP_INSERT, 16'h8000, 5'd0,  1'b1, 5'd4,  ST_OK},
    '{OP_INSERT, 16'h8000, 5'd0,  1'b1, 5'd5,  ST_OK},
    '{OP_WALK,   16'h0000, 5'd0,  1'b0, 5'd0,  ST_OK},
    '{OP_REMOVE, 16'h0000, 5'd3,  1'b1, 5'd3,  ST_OK},
    '{OP_REMOVE, 16'h0000, 5'd3,  1'b1, 5'd3,  ST_BAD_SLOT},
    '{OP_INSERT, 16'h8000, 5'd0,  1'b0, 5'd0,  ST_OK},
    '{OP_NONE,   16'h5A5A, 5'd21, 1'b0, 5'd0,  ST_OK},
    '{OP_WALK,   16'h0000, 5'd0,  1'b0, 5'd0,  ST_OK},
    '{OP_REMOVE, 16'h0000, 5'd1,  1'b1, 5'd1,  ST_OK},
    '{OP_REMOVE, 16'h0000, 5'd2,  1'b1, 5'd2,  ST_OK},
    '{OP_WALK,   16'h0000, 5'd0,  1'b0, 5'd0,  ST_OK},
    '{OP_INSERT, 16'h0000, 5'd0,  1'b0, 5'd0,  ST_OK},
    '{OP_INSERT, 16'hFFFF, 5'd0,  1'b0, 5'd0,  ST_OK},
    '{OP_INSERT, 16'h7FFF, 5'd0,  1'b0, 5'd0,  ST_OK},
    '{OP_WALK,   16'h0000, 5'd0,  1'b0, 5'd0,  ST_OK}
  };

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_op = OP_INSERT;
    in_priority_req = '0;
    in_slot = '0;
    row_typed = 1'b0;
    row_slot = '0;
    row_status = ST_OK;
    clear_ring();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (plan[i])
      issue_command(plan[i].op, plan[i].prio, plan[i].slot, plan[i].typed,
                    plan[i].e_slot, plan[i].e_status);

    // The directed words count toward the total.
    while (items_sent < RANDOM_ITEMS) begin
      no_idle = ($urandom_range(0, 4) == 0);
      case ($urandom_range(0, 2))
        0: begin
          // Fill to the brim, overflow once or twice, then walk the full ring.
          while (task_count() < MAX_TASKS)
            issue_command(OP_INSERT, pick_prio(), pick_any_slot());
          repeat ($urandom_range(1, 2))
            issue_command(OP_INSERT, pick_prio(), pick_any_slot());
          issue_command(OP_WALK, pick_prio(), pick_any_slot());
        end
        1: begin
          while (task_count() > 0) begin
            if ($urandom_range(0, 9) == 0)
              issue_command(OP_REMOVE, pick_prio(), pick_any_slot());
            else
              issue_command(OP_REMOVE, pick_prio(), pick_taken_slot());
            if ($urandom_range(0, 7) == 0)
              issue_command(OP_WALK, pick_prio(), pick_any_slot());
          end
          issue_command(OP_WALK, pick_prio(), pick_any_slot());
        end
        default: repeat (20) issue_random();
      endcase
    end
    start <= 1'b0;

    while (expected_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) $display("testbench passed");
    else $display("testbench failed");
    $finish;
  end

endmodule
